### sv/bgsd_pkg.sv
`default_nettype none
package bgsd_pkg;

	localparam int unsigned CFG_W     = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned SAMPLE_W  = 16;
	localparam int unsigned PAT_W     = 8;
	// diff * 8, signed: sign bit, 17-bit difference and three zero bits
	localparam int unsigned D8_W      = 21;
	// up to 9 * span, unsigned
	localparam int unsigned MULT_W    = 20;
	localparam int unsigned NUM_MULT  = 9;
	localparam int unsigned CNT_W     = 5;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LOW  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESS_HIGH = 2'd3;

	localparam logic [CFG_W-1:0] LIGHT_LOW_RST  = 16'd200;
	localparam logic [CFG_W-1:0] LIGHT_HIGH_RST = 16'd1250;
	localparam logic [CFG_W-1:0] PRESS_LOW_RST  = 16'd960;
	localparam logic [CFG_W-1:0] PRESS_HIGH_RST = 16'd1070;

	// serializer positions within the two-frame burst
	localparam logic [3:0]       BIT_MODE    = 4'd5;
	localparam logic [3:0]       BIT_ONE     = 4'd6;
	localparam logic [3:0]       BIT_FRAME   = 4'd7;
	localparam logic [3:0]       FRAME_END   = 4'd15;
	localparam logic [CNT_W-1:0] BURST_END   = 5'd31;

	localparam int unsigned QUEUE_DEPTH = 2;

	typedef struct packed {
		logic             mode;
		logic [PAT_W-1:0] pattern;
		logic             err;
	} job_t;

endpackage
`default_nettype wire

### sv/bgsd_if.sv
`default_nettype none
interface bgsd_in_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [15:0] sample_value;

	modport source (output valid, output mode, output sample_value, input ready);
	modport sink   (input valid, input mode, input sample_value, output ready);
endinterface

interface bgsd_out_if;
	logic valid;
	logic ready;
	logic serial_bit;
	logic latch_after;
	logic range_error;
	logic last;

	modport source (output valid, output serial_bit, output latch_after,
		output range_error, output last, input ready);
	modport sink   (input valid, input serial_bit, input latch_after,
		input range_error, input last, output ready);
endinterface
`default_nettype wire

### sv/bgsd_front.sv
`default_nettype none
module bgsd_front (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [bgsd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [bgsd_pkg::CFG_W-1:0]         cfg_wdata,
	bgsd_in_if.sink                                 in_ch,
	output logic                                    push,
	output bgsd_pkg::job_t                          push_job,
	input  wire logic                               push_ready
);

	logic [bgsd_pkg::CFG_W-1:0] light_low_q, light_high_q, press_low_q, press_high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_low_q  <= bgsd_pkg::LIGHT_LOW_RST;
			light_high_q <= bgsd_pkg::LIGHT_HIGH_RST;
			press_low_q  <= bgsd_pkg::PRESS_LOW_RST;
			press_high_q <= bgsd_pkg::PRESS_HIGH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				bgsd_pkg::CFG_LIGHT_LOW:  light_low_q  <= cfg_wdata;
				bgsd_pkg::CFG_LIGHT_HIGH: light_high_q <= cfg_wdata;
				bgsd_pkg::CFG_PRESS_LOW:  press_low_q  <= cfg_wdata;
				bgsd_pkg::CFG_PRESS_HIGH: press_high_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// stage 1: difference, span and span multiples
	logic [bgsd_pkg::CFG_W-1:0]  lo, hi;
	logic [bgsd_pkg::CFG_W:0]    diff, span;
	logic                        span_bad;
	logic                        accept;

	assign lo       = in_ch.mode ? press_low_q  : light_low_q;
	assign hi       = in_ch.mode ? press_high_q : light_high_q;
	assign diff     = {1'b0, in_ch.sample_value} - {1'b0, lo};
	assign span     = {1'b0, hi} - {1'b0, lo};
	assign span_bad = span[bgsd_pkg::CFG_W] || (span == '0);

	logic                         valid_s1;
	logic                         mode_s1;
	logic                         bad_s1;
	logic [bgsd_pkg::D8_W-1:0]    d8_s1;
	logic [bgsd_pkg::MULT_W-1:0]  mult_s1 [bgsd_pkg::NUM_MULT];

	assign in_ch.ready = !valid_s1 || push_ready;
	assign accept      = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= in_ch.mode;
			bad_s1  <= span_bad;
			d8_s1   <= {diff[bgsd_pkg::CFG_W], diff, 3'b000};
			for (int k = 0; k < bgsd_pkg::NUM_MULT; k++) begin
				mult_s1[k] <= bgsd_pkg::MULT_W'(span[bgsd_pkg::CFG_W-1:0])
					* bgsd_pkg::MULT_W'(k + 1);
			end
		end
	end

	// stage 2: compare against the multiples, thermometer falls out directly
	logic                        neg;
	logic [bgsd_pkg::D8_W-1:0]   neg_sum;
	logic                        neg_err, over_err;
	logic [bgsd_pkg::PAT_W-1:0]  pattern;

	assign neg      = d8_s1[bgsd_pkg::D8_W-1];
	// below low by an eighth of the span or more: level truncates to -1 or less
	assign neg_sum  = d8_s1 + {1'b0, mult_s1[0]};
	assign neg_err  = neg && (neg_sum[bgsd_pkg::D8_W-1] || (neg_sum == '0));
	assign over_err = !neg && (d8_s1[bgsd_pkg::MULT_W-1:0] >= mult_s1[bgsd_pkg::NUM_MULT-1]);

	always_comb begin
		for (int i = 0; i < bgsd_pkg::PAT_W; i++) begin
			pattern[bgsd_pkg::PAT_W-1-i] = !neg
				&& (d8_s1[bgsd_pkg::MULT_W-1:0] >= mult_s1[i]);
		end
	end

	assign push             = valid_s1 && push_ready;
	assign push_job.mode    = mode_s1;
	assign push_job.pattern = pattern;
	assign push_job.err     = bad_s1 || neg_err || over_err;

endmodule
`default_nettype wire

### sv/bgsd_queue.sv
`default_nettype none
module bgsd_queue #(
	parameter int unsigned DEPTH = bgsd_pkg::QUEUE_DEPTH
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  bgsd_pkg::job_t      push_job,
	output logic                push_ready,
	input  wire logic           pop,
	output bgsd_pkg::job_t      head,
	output logic                head_valid
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	bgsd_pkg::job_t   entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

### sv/bgsd_back.sv
`default_nettype none
module bgsd_back (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  bgsd_pkg::job_t  head,
	input  wire logic       head_valid,
	output logic            pop,
	bgsd_out_if.source      out_ch
);

	logic [bgsd_pkg::CNT_W-1:0] cnt_q;
	logic                       valid_q;
	logic                       bit_q, latch_q, err_q, last_q;
	logic                       load, emit, burst_done;
	logic [3:0]                 pos;
	logic                       nxt_bit;

	assign load       = !valid_q || out_ch.ready;
	assign emit       = load && head_valid;
	assign burst_done = (cnt_q == bgsd_pkg::BURST_END);
	assign pop        = emit && (head.err || burst_done);
	assign pos        = cnt_q[3:0];

	// frame = {5'b0, mode, 1, frame index, pattern}: rows 2/3 or 6/7
	always_comb begin
		if (pos[3]) begin
			nxt_bit = head.pattern[3'(~pos[2:0])];
		end else if (pos == bgsd_pkg::BIT_MODE) begin
			nxt_bit = head.mode;
		end else if (pos == bgsd_pkg::BIT_ONE) begin
			nxt_bit = 1'b1;
		end else if (pos == bgsd_pkg::BIT_FRAME) begin
			nxt_bit = cnt_q[4];
		end else begin
			nxt_bit = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= head_valid;
			end
			if (pop) begin
				cnt_q <= '0;
			end else if (emit) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (head.err) begin
				bit_q   <= 1'b0;
				latch_q <= 1'b0;
				err_q   <= 1'b1;
				last_q  <= 1'b1;
			end else begin
				bit_q   <= nxt_bit;
				latch_q <= (pos == bgsd_pkg::FRAME_END);
				err_q   <= 1'b0;
				last_q  <= burst_done;
			end
		end
	end

	assign out_ch.valid       = valid_q;
	assign out_ch.serial_bit  = bit_q;
	assign out_ch.latch_after = latch_q;
	assign out_ch.range_error = err_q;
	assign out_ch.last        = last_q;

endmodule
`default_nettype wire

### sv/bar_graph_serial_led_driver.sv
`default_nettype none
// A sample passes the front stage register, the queue and the output register in order.
// Throughput: a displayable sample yields 32 items, one per cycle while out_ch is ready,
// so the serializer paces the block; a range error yields one item.
// A new sample is taken while the previous one is still being shifted out.
// Reset (arst_n low, asynchronous): queue and output empty, bounds back to defaults.
module bar_graph_serial_led_driver #(
	parameter int unsigned QUEUE_DEPTH = bgsd_pkg::QUEUE_DEPTH
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [bgsd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bgsd_pkg::CFG_W-1:0]     cfg_wdata,
	bgsd_in_if.sink                             in_ch,
	bgsd_out_if.source                          out_ch
);

	// front -> queue
	logic           push;
	logic           push_ready;
	bgsd_pkg::job_t push_job;

	// queue -> back
	bgsd_pkg::job_t head;
	logic           head_valid;
	logic           pop;

	// Front: holds the bound registers, takes the sample, works out
	// sample - low and the span, then compares 8*(sample - low) with
	// 1..9 times the span. The compares give the thermometer byte bit by
	// bit; the ninth compare, the negative test and an empty span flag the error.
	bgsd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_ch      (in_ch),
		.push       (push),
		.push_job   (push_job),
		.push_ready (push_ready)
	);

	// Short queue of classified jobs: lets the front take the next sample
	// while the back is still shifting out the current one.
	bgsd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.push_ready (push_ready),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	// Back: a 5-bit bit counter walks the two 16-bit frames MSB first
	// (lower row, then upper row), marking the latch at each frame end,
	// into a registered output stage. Error jobs give one flagged item.
	bgsd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.out_ch     (out_ch)
	);

endmodule
`default_nettype wire

### bench/tb_bar_graph_serial_led_driver.sv
`timescale 1ns / 1ps
// Bar-graph serial LED driver bench.
// Each sample item sent in predicts its burst of serial-bit items: 32 bits for a
// displayable bar (two row frames), or one flagged item when the level cannot be
// shown. A scoreboard queue holds the predicted bits; the output side pops and
// compares them field by field. Bounds are reprogrammed only with the block empty.
module tb_bar_graph_serial_led_driver;

	// generous ceiling for the whole run of about 120 samples
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int MAX_PRINTED = 40;
	localparam int FRAME_W     = 16;
	localparam int BAR_MAX     = 8;
	// settle time after the last predicted item has left
	localparam int SETTLE      = 6;
	localparam int LONG_HOLD   = 300;

	localparam logic       MODE_LIGHT = 1'b0;
	localparam logic       MODE_PRESS = 1'b1;
	localparam logic [7:0] LIGHT_ROW  = 8'd2;
	localparam logic [7:0] PRESS_ROW  = 8'd6;

	typedef struct packed {
		logic serial_bit;
		logic latch_after;
		logic range_error;
		logic last;
	} led_bit_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [bgsd_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [bgsd_pkg::CFG_W-1:0]     cfg_wdata;

	bgsd_in_if  in_ch ();
	bgsd_out_if out_ch ();

	bar_graph_serial_led_driver u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// bench copy of the bound registers
	logic [bgsd_pkg::CFG_W-1:0] light_low_q;
	logic [bgsd_pkg::CFG_W-1:0] light_high_q;
	logic [bgsd_pkg::CFG_W-1:0] press_low_q;
	logic [bgsd_pkg::CFG_W-1:0] press_high_q;

	// predicted serial bits, oldest first
	led_bit_t pending_bits[$];

	int err_count;
	int cycle_count;
	bit src_gaps_on;
	bit sink_gaps_on;
	int hold_off_req;   // set by a test, taken up by the sink process
	int sink_hold;      // stall cycles left, owned by the sink process

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		if ($urandom_range(0, 99) < 8)
			return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	// Level = (sample - low) * 8 / span, truncated toward zero. Empty span or a
	// level outside 0..8 gives one error item; otherwise two frames MSB first.
	function automatic void predict_led_bits(input logic m,
		input logic [bgsd_pkg::SAMPLE_W-1:0] s);
		int              lo;
		int              hi;
		int              smp;
		int              span;
		int              level;
		logic [15:0]     shifted;
		logic [7:0]      bar;
		logic [7:0]      row;
		logic [FRAME_W-1:0] frame;
		led_bit_t        item;
		lo    = m ? press_low_q : light_low_q;
		hi    = m ? press_high_q : light_high_q;
		smp   = s;
		span  = hi - lo;
		level = -1;
		if (span > 0)
			level = ((smp - lo) * BAR_MAX) / span;
		if (span <= 0 || level < 0 || level > BAR_MAX) begin
			item = '{serial_bit: 1'b0, latch_after: 1'b0, range_error: 1'b1, last: 1'b1};
			pending_bits.push_back(item);
			return;
		end
		// thermometer byte: level ones from the MSB
		shifted = 16'hFF00 >> level;
		bar     = shifted[7:0];
		row     = m ? PRESS_ROW : LIGHT_ROW;
		for (int f = 0; f < 2; f++) begin
			frame = {row + 8'(f), bar};
			for (int b = FRAME_W - 1; b >= 0; b--) begin
				item.serial_bit  = frame[b];
				item.latch_after = (b == 0);
				item.range_error = 1'b0;
				item.last        = (b == 0) && (f == 1);
				pending_bits.push_back(item);
			end
		end
	endfunction

	// mostly inside the current bounds, some near the edges, some anywhere
	function automatic logic [bgsd_pkg::SAMPLE_W-1:0] gen_sample(input logic m);
		int lo;
		int hi;
		int v;
		int r;
		lo = m ? press_low_q : light_low_q;
		hi = m ? press_high_q : light_high_q;
		r  = $urandom_range(0, 99);
		if (r < 70 && hi > lo)
			v = lo + int'($urandom_range(0, hi - lo));
		else if (r < 85)
			v = ($urandom_range(0, 1) ? lo : hi) + int'($urandom_range(0, 16)) - 8;
		else
			v = $urandom_range(0, 65535);
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return v[bgsd_pkg::SAMPLE_W-1:0];
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		if (err_count < MAX_PRINTED)
			$display("MISMATCH %s: got %0d want %0d (cycle %0d)", what, got, want, cycle_count);
		err_count++;
	endtask

	// Offer one sample item and hold it until the block takes it.
	task automatic send_item(input logic m, input logic [bgsd_pkg::SAMPLE_W-1:0] s);
		int gap;
		if (src_gaps_on && $urandom_range(0, 2) == 0) begin
			gap = pick_gap();
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid        <= 1'b1;
		in_ch.mode         <= m;
		in_ch.sample_value <= s;
		do
			@(posedge clk);
		while (!in_ch.ready);
	endtask

	task automatic send_random(input int n);
		logic m;
		for (int i = 0; i < n; i++) begin
			m = 1'($urandom_range(0, 1));
			send_item(m, gen_sample(m));
		end
	endtask

	// Stop offering, wait for every predicted bit, then let the pipe settle.
	// One edge first so the prediction for the last accepted item is queued.
	task automatic quiesce();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_bits.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic put_reg(input logic [bgsd_pkg::CFG_IDX_W-1:0] idx,
		input logic [bgsd_pkg::CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	// only called with the block empty
	task automatic write_bounds(input logic [bgsd_pkg::CFG_W-1:0] ll,
		input logic [bgsd_pkg::CFG_W-1:0] lh,
		input logic [bgsd_pkg::CFG_W-1:0] pl, input logic [bgsd_pkg::CFG_W-1:0] ph);
		put_reg(bgsd_pkg::CFG_LIGHT_LOW, ll);
		put_reg(bgsd_pkg::CFG_LIGHT_HIGH, lh);
		put_reg(bgsd_pkg::CFG_PRESS_LOW, pl);
		put_reg(bgsd_pkg::CFG_PRESS_HIGH, ph);
		cfg_we       <= 1'b0;
		light_low_q  = ll;
		light_high_q = lh;
		press_low_q  = pl;
		press_high_q = ph;
		@(posedge clk);
	endtask

	// Reset bounds, no idling: every bar length in both channels, plus the
	// edges: zero and full-scale samples, and a sample just below low, which
	// truncates to an empty bar rather than an error.
	task automatic test_default_bars();
		int lo;
		int span;
		src_gaps_on  = 0;
		sink_gaps_on = 0;
		for (int mi = 0; mi < 2; mi++) begin
			lo   = mi ? press_low_q : light_low_q;
			span = (mi ? press_high_q : light_high_q) - lo;
			for (int lvl = 0; lvl <= BAR_MAX; lvl++)
				send_item(mi[0], bgsd_pkg::SAMPLE_W'(lo + (lvl * span + 7) / 8));
			send_item(mi[0], bgsd_pkg::SAMPLE_W'(lo - 1));
		end
		send_item(MODE_LIGHT, 16'd0);        // far below low: negative level
		send_item(MODE_PRESS, 16'hFFFF);     // far above high: level past 8
		send_item(MODE_LIGHT, 16'hFFFF);
		send_item(MODE_PRESS, 16'd0);
		quiesce();
	endtask

	task automatic test_random_default();
		src_gaps_on  = 1;
		sink_gaps_on = 1;
		send_random(20);
		quiesce();
	endtask

	// Sink holds off for a long stretch while samples keep coming: the queue
	// fills and input ready must drop, then everything drains in order.
	task automatic test_output_backpressure();
		logic m;
		src_gaps_on  = 0;
		sink_gaps_on = 0;
		hold_off_req = LONG_HOLD;
		for (int i = 0; i < 8; i++) begin
			m = i[0];
			send_item(m, (m ? press_low_q : light_low_q) + bgsd_pkg::SAMPLE_W'(i * 12));
		end
		quiesce();
	endtask

	// Widest light span and the narrowest possible pressure span.
	task automatic test_extreme_spans();
		write_bounds(16'd0, 16'hFFFF, 16'd0, 16'd1);
		src_gaps_on  = 1;
		sink_gaps_on = 1;
		send_item(MODE_LIGHT, 16'd0);
		send_item(MODE_LIGHT, 16'hFFFF);
		send_item(MODE_LIGHT, 16'h7FFF);
		send_item(MODE_PRESS, 16'd0);
		send_item(MODE_PRESS, 16'd1);
		send_item(MODE_PRESS, 16'd2);
		send_random(20);
		quiesce();
	endtask

	// high == low on light and high < low on pressure, then the reverse: every sample is an error item.
	task automatic test_empty_range();
		write_bounds(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
		send_item(MODE_LIGHT, 16'hFFFF);
		send_item(MODE_PRESS, 16'd0);
		send_item(MODE_PRESS, 16'h8000);
		send_random(5);
		quiesce();
		write_bounds(16'd501, 16'd500, 16'd1000, 16'd1000);
		send_item(MODE_LIGHT, 16'd500);
		send_item(MODE_PRESS, 16'd1000);
		quiesce();
	endtask

	task automatic test_random_bounds();
		logic [bgsd_pkg::CFG_W-1:0] b[4];
		int                         lo;
		int                         hi;
		for (int round = 0; round < 3; round++) begin
			for (int ch = 0; ch < 2; ch++) begin
				lo = $urandom_range(0, 65535);
				if ($urandom_range(0, 9) < 8)
					hi = lo + int'($urandom_range(1, 2000));
				else
					hi = $urandom_range(0, 65535);
				if (hi > 65535)
					hi = 65535;
				b[2 * ch]     = lo[bgsd_pkg::CFG_W-1:0];
				b[2 * ch + 1] = hi[bgsd_pkg::CFG_W-1:0];
			end
			write_bounds(b[0], b[1], b[2], b[3]);
			send_random(10);
			quiesce();
		end
	endtask

	// Output ready: random stalls at any point of a burst, plus the one long
	// hold-off a test can request, counted here.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (hold_off_req != 0) begin
				sink_hold    = hold_off_req;
				hold_off_req = 0;
			end else if (sink_hold == 0 && sink_gaps_on && $urandom_range(0, 3) == 0) begin
				sink_hold = pick_gap();
			end
			if (sink_hold > 0) begin
				out_ch.ready <= 1'b0;
				sink_hold--;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// Scoreboard: predict on input acceptance, compare on output acceptance.
	// Both read pre-edge values; a sample's first bit cannot leave on the edge
	// that takes it, so the push always comes first.
	always @(posedge clk) begin : scoreboard
		led_bit_t want;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				predict_led_bits(in_ch.mode, in_ch.sample_value);
			if (out_ch.valid && out_ch.ready) begin
				if (pending_bits.size() == 0) begin
					report_mismatch("unexpected item", 1, 0);
				end else begin
					want = pending_bits.pop_front();
					if (out_ch.serial_bit !== want.serial_bit)
						report_mismatch("serial_bit", out_ch.serial_bit, want.serial_bit);
					if (out_ch.latch_after !== want.latch_after)
						report_mismatch("latch_after", out_ch.latch_after, want.latch_after);
					if (out_ch.range_error !== want.range_error)
						report_mismatch("range_error", out_ch.range_error, want.range_error);
					if (out_ch.last !== want.last)
						report_mismatch("last", out_ch.last, want.last);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TIMEOUT with %0d items outstanding", pending_bits.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = bgsd_pkg::CFG_LIGHT_LOW;
		cfg_wdata          = '0;
		in_ch.valid        = 1'b0;
		in_ch.mode         = MODE_LIGHT;
		in_ch.sample_value = '0;
		out_ch.ready       = 1'b0;
		light_low_q        = bgsd_pkg::LIGHT_LOW_RST;
		light_high_q       = bgsd_pkg::LIGHT_HIGH_RST;
		press_low_q        = bgsd_pkg::PRESS_LOW_RST;
		press_high_q       = bgsd_pkg::PRESS_HIGH_RST;
		err_count          = 0;
		cycle_count        = 0;
		src_gaps_on        = 0;
		sink_gaps_on       = 0;
		hold_off_req       = 0;
		sink_hold          = 0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_bars();
		test_random_default();
		test_output_backpressure();
		test_extreme_spans();
		test_empty_range();
		test_random_bounds();

		if (pending_bits.size() != 0)
			report_mismatch("items never seen", pending_bits.size(), 0);

		if (err_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

### filelist.f
sv/bgsd_pkg.sv
sv/bgsd_if.sv
sv/bgsd_front.sv
sv/bgsd_queue.sv
sv/bgsd_back.sv
sv/bar_graph_serial_led_driver.sv
bench/tb_bar_graph_serial_led_driver.sv
